### rtl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg: shared types, codes and helpers for the fixed-point ALU
// Word layouts, operation codes, divider sizing and saturation functions.
// ----------------------------------------------------------------------------
`default_nettype none

package fpa_pkg;

	localparam int FRAC_BITS = 8;
	// dividend is |a| shifted up by the fraction width
	localparam int NUM_W     = 32 + FRAC_BITS;
	localparam int DIV_STEPS = NUM_W;
	// front stage, one stage per quotient bit, back stage
	localparam int LATENCY   = DIV_STEPS + 2;

	localparam logic [3:0] KIND_ADD = 4'd0;
	localparam logic [3:0] KIND_SUB = 4'd1;
	localparam logic [3:0] KIND_MUL = 4'd2;
	localparam logic [3:0] KIND_DIV = 4'd3;
	localparam logic [3:0] KIND_MIN = 4'd4;
	localparam logic [3:0] KIND_MAX = 4'd5;
	localparam logic [3:0] KIND_INC = 4'd6;
	localparam logic [3:0] KIND_DEC = 4'd7;
	localparam logic [3:0] KIND_I2F = 4'd8;
	localparam logic [3:0] KIND_F2I = 4'd9;

	localparam logic [31:0] MAX_POS = 32'h7fff_ffff;
	localparam logic [31:0] MIN_NEG = 32'h8000_0000;

	typedef struct packed {
		logic [3:0]         kind;
		logic signed [31:0] a_raw;
		logic signed [31:0] b_raw;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] result_raw;
		logic               a_less;
		logic               a_equal;
		logic               a_greater;
		logic               overflowed;
		logic               divided_by_zero;
	} out_word_t;

	// word carried down the divider row
	typedef struct packed {
		logic [3:0]         kind;
		logic [31:0]        simple_res;
		logic               simple_ov;
		logic               lt;
		logic               eq;
		logic               gt;
		logic               dz;
		logic               neg;
		logic signed [63:0] prod;
		logic [NUM_W-1:0]   num;
		logic [NUM_W-1:0]   quo;
		logic [31:0]        rem;
		logic [31:0]        den;
	} pipe_t;

	// {overflow, saturated word} from a 33-bit signed sum
	function automatic logic [32:0] sat33(input logic [32:0] v);
		logic [32:0] r;
		if (v[32] != v[31]) begin
			r = v[32] ? {1'b1, MIN_NEG} : {1'b1, MAX_POS};
		end else begin
			r = {1'b0, v[31:0]};
		end
		return r;
	endfunction

	// {overflow, saturated word} from sign and magnitude
	function automatic logic [32:0] from_mag(input logic neg, input logic [63:0] mag);
		logic [32:0] r;
		if (neg) begin
			if (mag > 64'h8000_0000) begin
				r = {1'b1, MIN_NEG};
			end else begin
				r = {1'b0, 32'd0 - mag[31:0]};
			end
		end else begin
			if (mag > 64'h7fff_ffff) begin
				r = {1'b1, MAX_POS};
			end else begin
				r = {1'b0, mag[31:0]};
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/fpa_front.sv
// ----------------------------------------------------------------------------
// fpa_front: operand stage of the fixed-point ALU
// Finishes the simple operations, forms the product and sets up the
// divider row.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire fpa_pkg::in_word_t op,
	output logic                  valid_s1,
	output fpa_pkg::pipe_t        pipe_s1
);

	logic signed [31:0]                  a;
	logic signed [31:0]                  b;
	logic [32:0]                         sum_sat;
	logic [32:0]                         dif_sat;
	logic [32:0]                         inc_sat;
	logic [32:0]                         dec_sat;
	logic [31+fpa_pkg::FRAC_BITS:0]      i2f_w;
	logic [fpa_pkg::FRAC_BITS:0]         i2f_top;
	logic                                i2f_ov;
	logic [31:0]                         mag_a;
	logic [31:0]                         mag_b;
	logic [31:0]                         res;
	logic                                ov;
	fpa_pkg::pipe_t                      nxt;

	assign a = op.a_raw;
	assign b = op.b_raw;

	assign sum_sat = fpa_pkg::sat33({a[31], a} + {b[31], b});
	assign dif_sat = fpa_pkg::sat33({a[31], a} - {b[31], b});
	assign inc_sat = fpa_pkg::sat33({a[31], a} + 33'd1);
	assign dec_sat = fpa_pkg::sat33({a[31], a} - 33'd1);

	assign i2f_w   = {a, {fpa_pkg::FRAC_BITS{1'b0}}};
	assign i2f_top = i2f_w[31+fpa_pkg::FRAC_BITS:31];
	assign i2f_ov  = !((&i2f_top) || !(|i2f_top));

	assign mag_a = a[31] ? 32'd0 - a : a;
	assign mag_b = b[31] ? 32'd0 - b : b;

	always_comb begin
		res = 32'd0;
		ov  = 1'b0;
		unique case (op.kind)
			fpa_pkg::KIND_ADD: {ov, res} = sum_sat;
			fpa_pkg::KIND_SUB: {ov, res} = dif_sat;
			fpa_pkg::KIND_MIN: res = (a < b) ? a : b;
			fpa_pkg::KIND_MAX: res = (a > b) ? a : b;
			fpa_pkg::KIND_INC: {ov, res} = inc_sat;
			fpa_pkg::KIND_DEC: {ov, res} = dec_sat;
			fpa_pkg::KIND_I2F: begin
				ov  = i2f_ov;
				res = i2f_ov ? (a[31] ? fpa_pkg::MIN_NEG : fpa_pkg::MAX_POS) : i2f_w[31:0];
			end
			fpa_pkg::KIND_F2I: res = a >>> fpa_pkg::FRAC_BITS;
			default: begin
				res = 32'd0;
				ov  = 1'b0;
			end
		endcase
	end

	always_comb begin
		nxt            = '0;
		nxt.kind       = op.kind;
		nxt.simple_res = res;
		nxt.simple_ov  = ov;
		nxt.lt         = a < b;
		nxt.eq         = a == b;
		nxt.gt         = a > b;
		nxt.dz         = (op.kind == fpa_pkg::KIND_DIV) && (b == 32'sd0);
		nxt.neg        = a[31] ^ b[31];
		nxt.prod       = a * b;
		nxt.num        = {mag_a, {fpa_pkg::FRAC_BITS{1'b0}}};
		nxt.quo        = '0;
		nxt.rem        = 32'd0;
		nxt.den        = mag_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		pipe_s1 <= nxt;
	end

endmodule

`default_nettype wire

### rtl/fpa_div_cell.sv
// ----------------------------------------------------------------------------
// fpa_div_cell: one restoring-division cell
// Develops one quotient bit and hands the word to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_div_cell (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            valid_i,
	input  wire fpa_pkg::pipe_t  pipe_i,
	output logic                 valid_q,
	output fpa_pkg::pipe_t       pipe_q
);

	logic [32:0]    trial;
	logic [32:0]    diff;
	logic           ge;
	fpa_pkg::pipe_t nxt;

	// shift the next dividend bit into the partial remainder
	assign trial = {pipe_i.rem, pipe_i.num[fpa_pkg::NUM_W-1]};
	assign diff  = trial - {1'b0, pipe_i.den};
	assign ge    = trial >= {1'b0, pipe_i.den};

	always_comb begin
		nxt     = pipe_i;
		nxt.rem = ge ? diff[31:0] : trial[31:0];
		nxt.quo = {pipe_i.quo[fpa_pkg::NUM_W-2:0], ge};
		nxt.num = {pipe_i.num[fpa_pkg::NUM_W-2:0], 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		pipe_q <= nxt;
	end

endmodule

`default_nettype wire

### rtl/fpa_back.sv
// ----------------------------------------------------------------------------
// fpa_back: result stage of the fixed-point ALU
// Rounds product and quotient, saturates, selects and registers the word.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            valid_i,
	input  wire fpa_pkg::pipe_t  pipe_i,
	output logic                 done,
	output fpa_pkg::out_word_t   res
);

	logic [63:0]               pmag;
	logic [63:0]               pround;
	logic [32:0]               mul_sat;
	logic                      rnd_up;
	logic [fpa_pkg::NUM_W:0]   qround;
	logic [32:0]               div_sat;
	fpa_pkg::out_word_t        nxt;
	logic                      done_q;
	fpa_pkg::out_word_t        res_q;

	// round half away from zero on the magnitude
	assign pmag    = pipe_i.prod[63] ? 64'd0 - pipe_i.prod : pipe_i.prod;
	assign pround  = (pmag + (64'd1 << (fpa_pkg::FRAC_BITS - 1))) >> fpa_pkg::FRAC_BITS;
	assign mul_sat = fpa_pkg::from_mag(pipe_i.prod[63], pround);

	assign rnd_up  = {pipe_i.rem, 1'b0} >= {1'b0, pipe_i.den};
	assign qround  = {1'b0, pipe_i.quo} + {{fpa_pkg::NUM_W{1'b0}}, rnd_up};
	assign div_sat = fpa_pkg::from_mag(pipe_i.neg,
		{{(63 - fpa_pkg::NUM_W){1'b0}}, qround});

	always_comb begin
		nxt                 = '0;
		nxt.a_less          = pipe_i.lt;
		nxt.a_equal         = pipe_i.eq;
		nxt.a_greater       = pipe_i.gt;
		nxt.divided_by_zero = pipe_i.dz;
		priority if (pipe_i.kind == fpa_pkg::KIND_MUL) begin
			{nxt.overflowed, nxt.result_raw} = mul_sat;
		end else if (pipe_i.kind == fpa_pkg::KIND_DIV && pipe_i.dz) begin
			nxt.overflowed = 1'b0;
			nxt.result_raw = 32'sd0;
		end else if (pipe_i.kind == fpa_pkg::KIND_DIV) begin
			{nxt.overflowed, nxt.result_raw} = div_sat;
		end else begin
			nxt.overflowed = pipe_i.simple_ov;
			nxt.result_raw = pipe_i.simple_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= nxt;
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

`default_nettype wire

### rtl/fixed_point_alu.sv
// ----------------------------------------------------------------------------
// fixed_point_alu: signed Q24.8 fixed-point ALU
// Add, subtract, multiply, divide, min, max, step and format conversion.
// ----------------------------------------------------------------------------
// A command word is taken on every clock where start is high; busy is never
// raised, so one word per cycle is sustained. Each result appears on res for
// one cycle with done high, in issue order. Every command passes through the
// divider: a row of one-bit restoring cells, one per dividend bit (32 plus the
// fraction bits), with one operand stage before and one rounding stage after.
// Every operation takes the same path, so results never reorder.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_point_alu (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire fpa_pkg::in_word_t op,
	output logic                   done,
	output fpa_pkg::out_word_t     res
);

	logic           valid_c [0:fpa_pkg::DIV_STEPS];
	fpa_pkg::pipe_t pipe_c  [0:fpa_pkg::DIV_STEPS];

	assign busy = 1'b0;

	fpa_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.op       (op),
		.valid_s1 (valid_c[0]),
		.pipe_s1  (pipe_c[0])
	);

	for (genvar i = 0; i < fpa_pkg::DIV_STEPS; i++) begin : g_cell
		fpa_div_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.valid_i (valid_c[i]),
			.pipe_i  (pipe_c[i]),
			.valid_q (valid_c[i+1]),
			.pipe_q  (pipe_c[i+1])
		);
	end

	fpa_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_i (valid_c[fpa_pkg::DIV_STEPS]),
		.pipe_i  (pipe_c[fpa_pkg::DIV_STEPS]),
		.done    (done),
		.res     (res)
	);

`ifndef SYNTHESIS
	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, fpa_pkg::LATENCY))
		else $error("done without a matching start");

	a_flags_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $onehot({res.a_less, res.a_equal, res.a_greater}))
		else $error("comparison flags not one-hot");

	a_dz_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && res.divided_by_zero) |-> (res.result_raw == 32'sd0 && !res.overflowed))
		else $error("divide by zero gave nonzero result or overflow");

	a_ov_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(done && res.overflowed) |->
		(res.result_raw == fpa_pkg::MAX_POS || res.result_raw == fpa_pkg::MIN_NEG))
		else $error("overflow flagged off a saturation limit");
`endif

endmodule

`default_nettype wire
